### hw/rtl/sttt_pkg.sv
// shared types and constants for the session token table
package sttt_pkg;

	localparam logic CMD_ISSUE = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam logic [31:0] TTL_RESET = 32'd21600000;
	localparam logic [31:0] EXP_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [63:0] w3;
		logic [63:0] w2;
		logic [63:0] w1;
		logic [63:0] w0;
	} token_t;

endpackage

### hw/rtl/sttt_req_if.sv
// request channel: command, time and token
interface sttt_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] now_ms;
	logic [63:0] token_w0;
	logic [63:0] token_w1;
	logic [63:0] token_w2;
	logic [63:0] token_w3;

	modport source (output valid, cmd, now_ms, token_w0, token_w1, token_w2, token_w3,
		input ready);
	modport sink (input valid, cmd, now_ms, token_w0, token_w1, token_w2, token_w3,
		output ready);
endinterface

### hw/rtl/sttt_rsp_if.sv
// response channel: hit flag, slot and expiry
interface sttt_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [1:0]  slot_index;
	logic [31:0] expiry_ms;

	modport source (output valid, hit, slot_index, expiry_ms, input ready);
	modport sink (input valid, hit, slot_index, expiry_ms, output ready);
endinterface

### hw/rtl/sttt_store.sv
// slot storage: token and expiry memories plus per-slot valid flags
module sttt_store #(
	parameter int SLOTS = 4,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  sttt_pkg::token_t   wr_token,
	input  logic [31:0]        wr_expiry,
	output logic               rd_valid,
	output sttt_pkg::token_t   rd_token,
	output logic [31:0]        rd_expiry
);
	import sttt_pkg::*;

	token_t            tok_mem [SLOTS];
	logic [31:0]       exp_mem [SLOTS];
	logic [SLOTS-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tok_mem[wr_addr] <= wr_token;
			exp_mem[wr_addr] <= wr_expiry;
		end
		if (rd_en) begin
			rd_token  <= tok_mem[rd_addr];
			rd_expiry <= exp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_valid <= valid_q[rd_addr];
		end
	end

endmodule

### hw/rtl/sttt_ctrl.sv
// sequencer: walks the slots one per cycle, picks the target, writes back on an issue, returns the result
module sttt_ctrl #(
	parameter int SLOTS = 4,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W = $clog2(SLOTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	sttt_req_if.sink           req,
	sttt_rsp_if.source         rsp,
	input  logic [31:0]        ttl_ms,
	output logic               rd_en,
	output logic [IDX_W-1:0]   rd_addr,
	input  logic               rd_valid,
	input  sttt_pkg::token_t   rd_token,
	input  logic [31:0]        rd_expiry,
	output logic               wr_en,
	output logic [IDX_W-1:0]   wr_addr,
	output sttt_pkg::token_t   wr_token,
	output logic [31:0]        wr_expiry
);
	import sttt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              ev_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic              rsp_vld_q;

	logic              cmd_q;
	logic [31:0]       now_q;
	token_t            tok_q;
	logic [31:0]       exp_new_q;
	logic [31:0]       soonest_q;
	logic [IDX_W-1:0]  best_q;
	logic [IDX_W-1:0]  fslot_q;
	logic [31:0]       mexp_q;

	logic              hit_q;
	logic [1:0]        slot_q;
	logic [31:0]       expiry_q;

	logic              accept;
	logic              expired;
	logic              issue_take;
	logic              check_take;
	logic              take;
	logic              closer;
	logic              scan_end;
	logic              out_free;
	logic [IDX_W-1:0]  sel_slot;
	logic [IDX_W+1:0]  slot_ext;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(SLOTS));
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	// read data of the slot fetched last cycle is judged here
	assign expired    = now_q > rd_expiry;
	assign issue_take = !rd_valid || expired;
	assign check_take = rd_valid && !expired && (rd_token == tok_q);
	assign take       = ev_s1 && !found_q &&
		((cmd_q == CMD_ISSUE) ? issue_take : check_take);
	assign closer     = ev_s1 && !found_q && (cmd_q == CMD_ISSUE) && !issue_take &&
		(rd_expiry < soonest_q);

	assign scan_end = (state_q == ST_SCAN) && (rd_cnt_q == CNT_W'(SLOTS)) && !ev_s1;
	assign out_free = !rsp_vld_q || rsp.ready;

	assign sel_slot = found_q ? fslot_q : best_q;
	assign slot_ext = {2'b00, sel_slot};

	// reads and the write-back never share a cycle, so no forwarding is needed
	assign wr_en     = (state_q == ST_WRITE);
	assign wr_addr   = sel_slot;
	assign wr_token  = tok_q;
	assign wr_expiry = exp_new_q;

	assign rsp.valid      = rsp_vld_q;
	assign rsp.hit        = hit_q;
	assign rsp.slot_index = slot_q;
	assign rsp.expiry_ms  = expiry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= '0;
			ev_s1     <= 1'b0;
			found_q   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			ev_s1 <= rd_en;
			if (rd_en)
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			if (take)
				found_q <= 1'b1;
			if ((state_q == ST_DONE) && out_free)
				rsp_vld_q <= 1'b1;
			else if (rsp.ready)
				rsp_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end)
						state_q <= (cmd_q == CMD_ISSUE) ? ST_WRITE : ST_DONE;
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (accept) begin
			cmd_q     <= req.cmd;
			now_q     <= req.now_ms;
			tok_q     <= '{w3: req.token_w3, w2: req.token_w2,
				w1: req.token_w1, w0: req.token_w0};
			exp_new_q <= req.now_ms + ttl_ms;
			soonest_q <= EXP_MAX;
			best_q    <= '0;
			fslot_q   <= '0;
			mexp_q    <= '0;
		end
		if (take) begin
			fslot_q <= idx_s1;
			if (cmd_q == CMD_CHECK)
				mexp_q <= rd_expiry;
		end
		if (closer) begin
			soonest_q <= rd_expiry;
			best_q    <= idx_s1;
		end
		if ((state_q == ST_DONE) && out_free) begin
			slot_q <= slot_ext[1:0];
			if (cmd_q == CMD_ISSUE) begin
				hit_q    <= 1'b1;
				expiry_q <= exp_new_q;
			end else begin
				hit_q    <= found_q;
				expiry_q <= mexp_q;
			end
		end
	end

endmodule

### hw/rtl/session_token_table_ttl_top.sv
// session token table with ttl and earliest-expiry eviction, top level
//
//  channel  dir  handshake        payload
//  req      in   valid/ready      cmd, now_ms, token_w0..token_w3
//  rsp      out  valid/ready      hit, slot_index, expiry_ms
//  cfg      in   cfg_we           cfg_wdata = ttl_ms
//
// a request walks the slots in ST_SCAN, an issue then writes back in ST_WRITE, and both
// end in ST_DONE, which loads the result and returns to ST_IDLE for the next request; the
// slot walk reads one entry per cycle from the single read port of the slot memories.
// reset clears all valid flags at once and loads ttl_ms with six hours.
// one request is in flight at a time; a finished result sits in the output register
// and the next request is taken while it waits, only the next result stalls on rsp.ready.
module session_token_table_ttl_top #(
	parameter int SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	sttt_req_if.sink    req,
	sttt_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import sttt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [31:0]       ttl_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_valid;
	token_t            rd_token;
	logic [31:0]       rd_expiry;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	token_t            wr_token;
	logic [31:0]       wr_expiry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ttl_q <= TTL_RESET;
		else if (cfg_we)
			ttl_q <= cfg_wdata;
	end

	sttt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ttl_ms    (ttl_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_valid  (rd_valid),
		.rd_token  (rd_token),
		.rd_expiry (rd_expiry),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_token  (wr_token),
		.wr_expiry (wr_expiry)
	);

	sttt_store #(.SLOTS(SLOTS)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_token  (wr_token),
		.wr_expiry (wr_expiry),
		.rd_valid  (rd_valid),
		.rd_token  (rd_token),
		.rd_expiry (rd_expiry)
	);

	// the write-back never overlaps the slot walk
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("slot read and write in the same cycle");

	// once a request is taken the block stays busy for the walk
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while the previous one is in flight");

	// accesses stay within the table
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en |-> (rd_addr < SLOTS)) and (wr_en |-> (wr_addr < SLOTS)))
		else $error("slot address out of range");

endmodule
